// File: design/windowed_median_mad_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the median / MAD tracker
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEDIAN_MAD_TRACKER_CORE_MACROS_SVH
`define WINDOWED_MEDIAN_MAD_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define WMMT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WMMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/wmmt_pkg.sv
// ----------------------------------------------------------------------------
// wmmt_pkg
// Field widths, register indexes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package wmmt_pkg;

	localparam int STAMP_W    = 63;
	localparam int OFS_W      = 64;
	localparam int DEV_W      = 63;
	localparam int HCNT_W     = 4;
	localparam int THR_W      = 30;
	localparam int MINC_W     = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int SUM_W      = OFS_W + 1;

	localparam logic [THR_W-1:0]  THR_RESET  = 30'd15000000;
	localparam logic [MINC_W-1:0] MINC_RESET = 4'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT       = 8'd1;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_LO   = 2'd1,
		RD_HI   = 2'd2,
		RD_K    = 2'd3
	} rd_op_t;

	typedef struct packed {
		logic   load;
		logic   calc_offset;
		rd_op_t rd_op;
		logic   use_dev;
		logic   sum;
		logic   mid;
		logic   diff;
		logic   check;
		logic   read_old;
		logic   del;
		logic   ins;
		logic   dev_start;
		logic   emit;
	} cmd_t;

	typedef struct packed {
		logic nonempty;
		logic full;
		logic outlier;
		logic valid_after_ins;
		logic dev_last;
		logic out_free;
	} sts_t;

endpackage

// File: design/wmmt_sample_if.sv
// ----------------------------------------------------------------------------
// wmmt_sample_if
// Input request channel: one audio/video timestamp pair per request.
// ----------------------------------------------------------------------------
interface wmmt_sample_if;
	logic                           valid;
	logic                           ready;
	logic [wmmt_pkg::STAMP_W-1:0]   audio_stamp;
	logic [wmmt_pkg::STAMP_W-1:0]   video_stamp;
	logic                           ctx_flush;

	modport source (output valid, audio_stamp, video_stamp, ctx_flush, input ready);
	modport sink   (input valid, audio_stamp, video_stamp, ctx_flush, output ready);
endinterface

// File: design/wmmt_result_if.sv
// ----------------------------------------------------------------------------
// wmmt_result_if
// Result request channel: offset, window median and deviation.
// ----------------------------------------------------------------------------
interface wmmt_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [wmmt_pkg::OFS_W-1:0]   raw_offset;
	logic                                stats_valid;
	logic signed [wmmt_pkg::OFS_W-1:0]   median_offset;
	logic [wmmt_pkg::DEV_W-1:0]          deviation;
	logic [wmmt_pkg::HCNT_W-1:0]         held_count;
	logic                                window_cleared;

	modport source (output valid, raw_offset, stats_valid, median_offset, deviation,
		held_count, window_cleared, input ready);
	modport sink   (input valid, raw_offset, stats_valid, median_offset, deviation,
		held_count, window_cleared, output ready);
endinterface

// File: design/wmmt_cfg_if.sv
// ----------------------------------------------------------------------------
// wmmt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wmmt_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [wmmt_pkg::CFG_IDX_W-1:0]     index;
	logic [wmmt_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/wmmt_ctrl.sv
// ----------------------------------------------------------------------------
// wmmt_ctrl
// Sequencer: steps the datapath through outlier check, window update,
// median, deviation sort and deviation median for each request.
// ----------------------------------------------------------------------------
module wmmt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wmmt_pkg::sts_t   sts,
	output wmmt_pkg::cmd_t   cmd
);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_OFS   = 15'b000000000000010,
		S_RLO   = 15'b000000000000100,
		S_RHI   = 15'b000000000001000,
		S_SUM   = 15'b000000000010000,
		S_MID   = 15'b000000000100000,
		S_DIFF  = 15'b000000001000000,
		S_CHK   = 15'b000000010000000,
		S_ROLD  = 15'b000000100000000,
		S_DEL   = 15'b000001000000000,
		S_INS   = 15'b000010000000000,
		S_DEVRD = 15'b000100000000000,
		S_DEVW1 = 15'b001000000000000,
		S_DEVW2 = 15'b010000000000000,
		S_OUT   = 15'b100000000000000
	} state_t;

	// which median the shared read/midpoint sequence is producing
	typedef enum logic [2:0] {
		PH_CHECK  = 3'b001,
		PH_MEDIAN = 3'b010,
		PH_DEV    = 3'b100
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_CHECK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cmd         = '0;
		cmd.use_dev = (phase_q == PH_DEV);
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_OFS;
				end
			end
			S_OFS: begin
				cmd.calc_offset = 1'b1;
				if (sts.nonempty) begin
					phase_d = PH_CHECK;
					state_d = S_RLO;
				end else begin
					state_d = S_INS;
				end
			end
			S_RLO: begin
				cmd.rd_op = wmmt_pkg::RD_LO;
				state_d   = S_RHI;
			end
			S_RHI: begin
				cmd.rd_op = wmmt_pkg::RD_HI;
				state_d   = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MID;
			end
			S_MID: begin
				cmd.mid = 1'b1;
				unique case (phase_q)
					PH_CHECK:  state_d = S_DIFF;
					PH_MEDIAN: begin
						cmd.dev_start = 1'b1;
						state_d       = S_DEVRD;
					end
					PH_DEV:    state_d = S_OUT;
					default:   state_d = S_IDLE;
				endcase
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				cmd.check = 1'b1;
				state_d   = (sts.full && !sts.outlier) ? S_ROLD : S_INS;
			end
			S_ROLD: begin
				cmd.read_old = 1'b1;
				state_d      = S_DEL;
			end
			S_DEL: begin
				cmd.del = 1'b1;
				state_d = S_INS;
			end
			S_INS: begin
				cmd.ins = 1'b1;
				if (sts.valid_after_ins) begin
					phase_d = PH_MEDIAN;
					state_d = S_RLO;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DEVRD: begin
				cmd.rd_op = wmmt_pkg::RD_K;
				if (sts.dev_last) state_d = S_DEVW1;
			end
			// let the last deviation drain into the sorted list
			S_DEVW1: state_d = S_DEVW2;
			S_DEVW2: begin
				phase_d = PH_DEV;
				state_d = S_RLO;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: design/wmmt_datapath.sv
// ----------------------------------------------------------------------------
// wmmt_datapath
// Offset ring, sorted offset list, sorted deviation list, shared midpoint
// adder, outlier compare, configuration registers and result register.
// ----------------------------------------------------------------------------
module wmmt_datapath #(
	parameter int WINDOW = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wmmt_pkg::cmd_t                        cmd,
	output wmmt_pkg::sts_t                        sts,
	input  logic [wmmt_pkg::STAMP_W-1:0]          audio_stamp,
	input  logic [wmmt_pkg::STAMP_W-1:0]          video_stamp,
	input  logic                                  ctx_flush,
	input  logic                                  cfg_valid,
	input  logic [wmmt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wmmt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [wmmt_pkg::OFS_W-1:0]     raw_offset,
	output logic                                  stats_valid,
	output logic signed [wmmt_pkg::OFS_W-1:0]     median_offset,
	output logic [wmmt_pkg::DEV_W-1:0]            deviation,
	output logic [wmmt_pkg::HCNT_W-1:0]           held_count,
	output logic                                  window_cleared
);

	localparam int OW = wmmt_pkg::OFS_W;
	localparam int SW = wmmt_pkg::SUM_W;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int IW = $clog2(WINDOW);
	localparam int VW = (CW + 1 > wmmt_pkg::MINC_W) ? CW + 1 : wmmt_pkg::MINC_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);
	localparam logic [CW:0]   W_SUM    = (CW + 1)'(WINDOW);
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);

	// configuration
	logic [wmmt_pkg::THR_W-1:0]  thr_q;
	logic [wmmt_pkg::MINC_W-1:0] minc_q;

	// control state
	logic [CW-1:0] cnt_q, dcnt_q, k_q;
	logic [IW-1:0] oldest_q;
	logic          cleared_q;
	logic          dev_v_s1, dev_v_s2;
	logic          out_valid_q;

	// payload
	logic [wmmt_pkg::STAMP_W-1:0] aud_q, vid_q;
	logic signed [OW-1:0] offset_q, med_q, old_q;
	logic [OW-1:0]        rd_q, a_q;
	logic [SW-1:0]        sum_q;
	logic signed [SW-1:0] d_q;
	logic [SW-1:0]        dev_diff_s2;
	logic [wmmt_pkg::DEV_W-1:0] dev_q;

	logic signed [OW-1:0] ring_q [WINDOW];
	logic signed [OW-1:0] srt_q  [WINDOW];
	logic [OW-1:0]        dsrt_q [WINDOW];
	logic signed [OW-1:0] srt_ins [WINDOW];
	logic signed [OW-1:0] srt_del [WINDOW];
	logic [OW-1:0]        dsrt_ins [WINDOW];
	logic [WINDOW-1:0]    ins_le, del_ge, dev_le;

	// comb helpers
	logic [CW-1:0]        lo_idx, hi_idx;
	logic [IW-1:0]        rd_idx, wr_addr;
	logic [CW:0]          wr_sum;
	logic [SW-1:0]        rnd;
	logic [OW-1:0]        mid_val;
	logic signed [SW-1:0] thr_pos, thr_neg;
	logic [SW-1:0]        dneg;
	logic [OW-1:0]        dmag;
	logic [VW-1:0]        min_v, cnt_v, cnt_p1_v;
	logic                 stats_now;

	assign lo_idx = (cnt_q - CW'(1)) >> 1;
	assign hi_idx = cnt_q >> 1;

	always_comb begin
		unique case (cmd.rd_op)
			wmmt_pkg::RD_LO:   rd_idx = lo_idx[IW-1:0];
			wmmt_pkg::RD_HI:   rd_idx = hi_idx[IW-1:0];
			wmmt_pkg::RD_K:    rd_idx = k_q[IW-1:0];
			wmmt_pkg::RD_NONE: rd_idx = '0;
		endcase
	end

	// next free ring slot, oldest + count taken modulo the window
	assign wr_sum  = (CW + 1)'(oldest_q) + (CW + 1)'(cnt_q);
	assign wr_addr = (wr_sum >= W_SUM) ? IW'(wr_sum - W_SUM) : IW'(wr_sum);

	// signed midpoint truncates toward zero: add the sign before the shift
	assign rnd     = sum_q + {{(SW - 1){1'b0}}, sum_q[SW-1]};
	assign mid_val = cmd.use_dev ? sum_q[SW-1:1] : rnd[SW-1:1];

	assign thr_pos = $signed({{(SW - wmmt_pkg::THR_W){1'b0}}, thr_q});
	assign thr_neg = -thr_pos;

	assign dneg = -dev_diff_s2;
	assign dmag = dev_diff_s2[SW-1] ? dneg[OW-1:0] : dev_diff_s2[OW-1:0];

	assign min_v     = VW'(minc_q);
	assign cnt_v     = VW'(cnt_q);
	assign cnt_p1_v  = cnt_v + VW'(1);
	assign stats_now = (cnt_v >= min_v);

	assign sts.nonempty        = (cnt_q != '0);
	assign sts.full            = (cnt_q == FULL_CNT);
	assign sts.outlier         = (d_q > thr_pos) || (d_q < thr_neg);
	assign sts.valid_after_ins = (cnt_p1_v >= min_v);
	assign sts.dev_last        = (k_q == cnt_q - CW'(1));
	assign sts.out_free        = !out_valid_q || out_ready;

	// per-cell compares for the sorted lists
	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		localparam logic [CW-1:0] G_IDX = CW'(g);
		assign ins_le[g] = (G_IDX < cnt_q) && (srt_q[g] <= offset_q);
		assign del_ge[g] = (G_IDX < cnt_q) && (srt_q[g] >= old_q);
		assign dev_le[g] = (G_IDX < dcnt_q) && (dsrt_q[g] <= dmag);
		if (g == 0) begin : g_first
			assign srt_ins[g]  = ins_le[g] ? srt_q[g] : offset_q;
			assign dsrt_ins[g] = dev_le[g] ? dsrt_q[g] : dmag;
		end else begin : g_rest
			assign srt_ins[g]  = ins_le[g] ? srt_q[g]
				: (ins_le[g-1] ? offset_q : srt_q[g-1]);
			assign dsrt_ins[g] = dev_le[g] ? dsrt_q[g]
				: (dev_le[g-1] ? dmag : dsrt_q[g-1]);
		end
		if (g == WINDOW - 1) begin : g_top
			assign srt_del[g] = srt_q[g];
		end else begin : g_low
			// first entry not below the dropped value is the one removed
			assign srt_del[g] = del_ge[g] ? srt_q[g+1] : srt_q[g];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= wmmt_pkg::THR_RESET;
			minc_q <= wmmt_pkg::MINC_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wmmt_pkg::REG_RESET_THRESHOLD: thr_q  <= cfg_data[wmmt_pkg::THR_W-1:0];
				wmmt_pkg::REG_MIN_COUNT:       minc_q <= cfg_data[wmmt_pkg::MINC_W-1:0];
				default: ;
			endcase
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			oldest_q  <= '0;
			cleared_q <= 1'b0;
			dcnt_q    <= '0;
			k_q       <= '0;
			dev_v_s1  <= 1'b0;
			dev_v_s2  <= 1'b0;
		end else begin
			dev_v_s1 <= (cmd.rd_op == wmmt_pkg::RD_K);
			dev_v_s2 <= dev_v_s1;
			if (cmd.load) begin
				cleared_q <= 1'b0;
				if (ctx_flush) begin
					cnt_q    <= '0;
					oldest_q <= '0;
				end
			end else if (cmd.check) begin
				if (sts.outlier) begin
					cnt_q     <= '0;
					oldest_q  <= '0;
					cleared_q <= 1'b1;
				end
			end else if (cmd.del) begin
				cnt_q    <= cnt_q - CW'(1);
				oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + IW'(1);
			end else if (cmd.ins) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.dev_start) begin
				dcnt_q <= '0;
				k_q    <= '0;
			end else begin
				if (cmd.rd_op == wmmt_pkg::RD_K) k_q <= k_q + CW'(1);
				if (dev_v_s2) dcnt_q <= dcnt_q + CW'(1);
			end
		end
	end

	// offset ring
	always_ff @(posedge clk) begin
		if (cmd.ins) ring_q[wr_addr] <= offset_q;
		if (cmd.read_old) old_q <= ring_q[oldest_q];
	end

	// sorted lists
	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW; i++) begin
			if (cmd.del) srt_q[i] <= srt_del[i];
			else if (cmd.ins) srt_q[i] <= srt_ins[i];
			if (dev_v_s2) dsrt_q[i] <= dsrt_ins[i];
		end
	end

	// arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			aud_q <= audio_stamp;
			vid_q <= video_stamp;
		end
		if (cmd.calc_offset) offset_q <= {1'b0, aud_q} - {1'b0, vid_q};
		if (cmd.rd_op != wmmt_pkg::RD_NONE) begin
			rd_q <= cmd.use_dev ? dsrt_q[rd_idx] : srt_q[rd_idx];
		end
		if (cmd.rd_op == wmmt_pkg::RD_HI) a_q <= rd_q;
		if (cmd.sum) begin
			sum_q <= cmd.use_dev ? ({1'b0, a_q} + {1'b0, rd_q})
				: ({a_q[OW-1], a_q} + {rd_q[OW-1], rd_q});
		end
		if (cmd.mid) begin
			if (cmd.use_dev) begin
				dev_q <= mid_val[OW-1] ? '1 : mid_val[wmmt_pkg::DEV_W-1:0];
			end else begin
				med_q <= mid_val;
			end
		end
		if (cmd.diff) d_q <= {offset_q[OW-1], offset_q} - {med_q[OW-1], med_q};
		if (dev_v_s1) dev_diff_s2 <= {rd_q[OW-1], rd_q} - {med_q[OW-1], med_q};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			raw_offset     <= offset_q;
			stats_valid    <= stats_now;
			median_offset  <= stats_now ? med_q : offset_q;
			deviation      <= stats_now ? dev_q : '0;
			held_count     <= wmmt_pkg::HCNT_W'(cnt_q);
			window_cleared <= cleared_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/windowed_median_mad_tracker_core.sv
// ----------------------------------------------------------------------------
// windowed_median_mad_tracker_core
// Tracks audio-minus-video offsets over a sliding window and reports the
// window median and median absolute deviation, one result per request.
// sample: audio/video stamps plus ctx_flush; result: offset, stats,
// held count and outlier-clear flag; cfg: register writes, always ready.
// One request is worked at a time: the sequencer steps a single sorted-list
// read port and one shared midpoint adder through three medians, and
// sample.ready rises again in the same cycle as result.valid; a window that
// is not yet valid after the update skips the median and deviation passes.
// The result register frees sample.ready as soon as the block is idle, so a
// new request can be taken while an older result waits on a stalled
// receiver; the next result then waits until the old one is taken.
// Reset empties the window at once (no clearing pass) and loads the
// threshold and minimum-count registers with their defaults.
// ----------------------------------------------------------------------------
`include "windowed_median_mad_tracker_core_macros.svh"

module windowed_median_mad_tracker_core #(
	parameter int WINDOW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	wmmt_sample_if.sink   sample,
	wmmt_result_if.source result,
	wmmt_cfg_if.sink      cfg
);

	wmmt_pkg::cmd_t cmd;
	wmmt_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	wmmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wmmt_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.audio_stamp     (sample.audio_stamp),
		.video_stamp     (sample.video_stamp),
		.ctx_flush       (sample.ctx_flush),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.raw_offset      (result.raw_offset),
		.stats_valid     (result.stats_valid),
		.median_offset   (result.median_offset),
		.deviation       (result.deviation),
		.held_count      (result.held_count),
		.window_cleared  (result.window_cleared)
	);

	// one request in flight: no accept right after an accept
	`WMMT_ASSERT_NEXT(a_single_request, sample.valid && sample.ready, !sample.ready,
		"request accepted while previous one in progress")

	// without stats the median echoes the offset and the deviation is zero
	`WMMT_ASSERT_IMPL(a_no_stats_fields, result.valid && !result.stats_valid,
		(result.deviation == '0) && (result.median_offset == result.raw_offset),
		"invalid stats carry non-default median or deviation")

	// an outlier clear leaves only the new offset in the window
	`WMMT_ASSERT_IMPL(a_clear_count, result.valid && result.window_cleared,
		result.held_count == wmmt_pkg::HCNT_W'(1),
		"outlier clear with more than one held offset")

endmodule

// File: dv/wmmt_stats_checker.sv
// ----------------------------------------------------------------------------
// wmmt_stats_checker
// Watches the sample, result and cfg channels, keeps its own offset ring and
// register copies, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmmt_stats_checker
	import wmmt_pkg::*;
#(
	parameter int WINDOW = 9
) (
	input  logic   clk,
	input  logic   arst_n,
	wmmt_sample_if sample,
	wmmt_result_if result,
	wmmt_cfg_if    cfg,
	output int     failures,
	output int     outstanding
);

	localparam logic [OFS_W-1:0] DEV_SAT = {1'b0, {DEV_W{1'b1}}};

	typedef struct packed {
		logic signed [OFS_W-1:0]  raw_offset;
		logic                     stats_valid;
		logic signed [OFS_W-1:0]  median_offset;
		logic [DEV_W-1:0]         deviation;
		logic [HCNT_W-1:0]        held_count;
		logic                     window_cleared;
	} sync_stats_t;

	logic signed [OFS_W-1:0] ring [WINDOW];
	int unsigned             fill;
	int unsigned             head;
	logic [THR_W-1:0]        thr_reg;
	logic [MINC_W-1:0]       minc_reg;
	sync_stats_t             stats_q [$];
	int                      mismatch_count = 0;

	function automatic logic [OFS_W-1:0] distance(input logic signed [OFS_W-1:0] a,
		input logic signed [OFS_W-1:0] b);
		if (a >= b)
			return OFS_W'(a - b);
		return OFS_W'(b - a);
	endfunction

	// even count: wide sum, signed divide truncates toward zero
	function automatic logic signed [OFS_W-1:0] offset_median(
		input logic signed [OFS_W-1:0] src [WINDOW], input int unsigned n);
		logic signed [OFS_W-1:0] v [WINDOW];
		logic signed [OFS_W-1:0] x;
		logic signed [SUM_W-1:0] s;
		int j;
		for (int i = 0; i < n; i++) begin
			x = src[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		if (n % 2 == 1)
			return v[n/2];
		s = v[n/2-1];
		s = s + v[n/2];
		return OFS_W'(s / 2);
	endfunction

	function automatic logic [OFS_W-1:0] spread_median(input logic [OFS_W-1:0] src [WINDOW],
		input int unsigned n);
		logic [OFS_W-1:0] v [WINDOW];
		logic [OFS_W-1:0] x;
		logic [SUM_W-1:0] s;
		int j;
		for (int i = 0; i < n; i++) begin
			x = src[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		if (n % 2 == 1)
			return v[n/2];
		s = {1'b0, v[n/2-1]} + {1'b0, v[n/2]};
		return s[SUM_W-1:1];
	endfunction

	function automatic sync_stats_t track_sample(input logic [STAMP_W-1:0] audio,
		input logic [STAMP_W-1:0] video, input logic ctx);
		sync_stats_t             r;
		logic signed [OFS_W-1:0] held [WINDOW];
		logic [OFS_W-1:0]        devs [WINDOW];
		logic [OFS_W-1:0]        d;
		logic signed [OFS_W-1:0] off;
		off = {1'b0, audio} - {1'b0, video};
		r = '0;
		r.raw_offset = off;
		r.median_offset = off;
		if (ctx) begin
			fill = 0;
			head = 0;
		end
		if (fill > 0) begin
			for (int i = 0; i < fill; i++)
				held[i] = ring[(head + i) % WINDOW];
			if (distance(off, offset_median(held, fill)) > OFS_W'(thr_reg)) begin
				fill = 0;
				head = 0;
				r.window_cleared = 1'b1;
			end
		end
		if (fill < WINDOW) begin
			ring[(head + fill) % WINDOW] = off;
			fill++;
		end else begin
			ring[head] = off;
			head = (head + 1) % WINDOW;
		end
		r.held_count = HCNT_W'(fill);
		r.stats_valid = (fill >= minc_reg);
		if (r.stats_valid) begin
			for (int i = 0; i < fill; i++)
				held[i] = ring[(head + i) % WINDOW];
			r.median_offset = offset_median(held, fill);
			for (int i = 0; i < fill; i++)
				devs[i] = distance(held[i], r.median_offset);
			d = spread_median(devs, fill);
			r.deviation = DEV_W'((d > DEV_SAT) ? DEV_SAT : d);
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic [OFS_W-1:0] want,
		input logic [OFS_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sync_stats_t want;
		if (!arst_n) begin
			fill = 0;
			head = 0;
			thr_reg = THR_RESET;
			minc_reg = MINC_RESET;
			stats_q.delete();
			outstanding <= 0;
			failures <= mismatch_count;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_RESET_THRESHOLD: thr_reg = cfg.data[THR_W-1:0];
					REG_MIN_COUNT:       minc_reg = cfg.data[MINC_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (stats_q.size() == 0) begin
					$error("result request with no sample pending");
					mismatch_count++;
				end else begin
					want = stats_q[0];
					stats_q.delete(0);
					check_field("raw_offset", want.raw_offset, result.raw_offset);
					check_field("stats_valid", OFS_W'(want.stats_valid),
						OFS_W'(result.stats_valid));
					check_field("median_offset", want.median_offset, result.median_offset);
					check_field("deviation", OFS_W'(want.deviation),
						OFS_W'(result.deviation));
					check_field("held_count", OFS_W'(want.held_count),
						OFS_W'(result.held_count));
					check_field("window_cleared", OFS_W'(want.window_cleared),
						OFS_W'(result.window_cleared));
				end
			end
			if (sample.valid && sample.ready)
				stats_q.insert(stats_q.size(), track_sample(sample.audio_stamp,
					sample.video_stamp, sample.ctx_flush));
			outstanding <= stats_q.size();
			failures <= mismatch_count;
		end
	end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives timestamp pairs and register writes into the median / MAD tracker
// with random gaps and result stalls; the stats checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import wmmt_pkg::*;

	localparam int WINDOW          = 9;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_TAIL      = 64;
	localparam int RAND_PHASES     = 8;
	localparam int PHASE_ITEMS     = 48;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
	localparam logic [OFS_W-1:0]   STAMP_MAX_W = {1'b0, STAMP_MAX};
	// keeps base offsets clear of the ends so jitter cannot wrap
	localparam longint OFS_EDGE    = 64'h7FFF_FFFB_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	bit   tx_steady;
	bit   rx_steady;
	int   stall_left;
	int   quiet_cycles;
	int   failures;
	int   outstanding;

	wmmt_sample_if sample();
	wmmt_result_if result();
	wmmt_cfg_if    cfg();

	windowed_median_mad_tracker_core #(.WINDOW(WINDOW)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	wmmt_stats_checker #(.WINDOW(WINDOW)) i_stats_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.cfg         (cfg),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [OFS_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic longint rand_between(input longint lo, input longint hi);
		logic [OFS_W-1:0] span;
		span = OFS_W'(hi - lo) + 1;
		return lo + longint'(rand64() % span);
	endfunction

	// result side: random stalls, with stretches of none
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
			stall_left = idle_len() - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// valid stays high after the request so a back-to-back one needs no drop
	task automatic send_sample(input logic [STAMP_W-1:0] a, input logic [STAMP_W-1:0] v,
		input logic c);
		int gap;
		gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.audio_stamp <= a;
		sample.video_stamp <= v;
		sample.ctx_flush <= c;
		do @(posedge clk); while (!sample.ready);
	endtask

	// picks stamps that give exactly this offset
	task automatic send_offset(input logic signed [OFS_W-1:0] off, input logic c);
		logic [OFS_W-1:0] mag;
		logic [OFS_W-1:0] a;
		logic [OFS_W-1:0] v;
		if (off >= 0) begin
			mag = off;
			v = rand64() % (STAMP_MAX_W - mag + 1);
			a = v + mag;
		end else begin
			mag = -off;
			v = mag + rand64() % (STAMP_MAX_W - mag + 1);
			a = v - mag;
		end
		send_sample(a[STAMP_W-1:0], v[STAMP_W-1:0], c);
	endtask

	task automatic wait_idle();
		sample.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= word;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// upper data bits are random: the block must drop them
	task automatic program_regs(input logic [THR_W-1:0] thr, input logic [MINC_W-1:0] minc);
		logic [CFG_DATA_W-1:0] word;
		word = $urandom;
		word[THR_W-1:0] = thr;
		cfg_write(REG_RESET_THRESHOLD, word);
		cfg_write(CFG_IDX_W'($urandom_range(int'(REG_MIN_COUNT) + 1, (1 << CFG_IDX_W) - 1)),
			$urandom);
		word = $urandom;
		word[MINC_W-1:0] = minc;
		cfg_write(REG_MIN_COUNT, word);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_phase(input int items, input logic [THR_W-1:0] thr);
		longint base;
		longint span;
		longint jit;
		int     r;
		span = longint'(thr);
		r = $urandom_range(0, 99);
		if (r < 40)
			base = rand_between(-1000000, 1000000);
		else if (r < 60)
			base = rand_between(OFS_EDGE - 1000, OFS_EDGE);
		else
			base = $signed(rand64()) >>> 1;
		if ($urandom_range(0, 1) == 1)
			base = -base;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_sample(STAMP_W'(rand64()), STAMP_W'(rand64()),
					1'($urandom_range(0, 1)));
			end else begin
				// mostly inside the threshold so the window fills and wraps
				if (r < 18)
					jit = rand_between(-(2 * span + 8), 2 * span + 8);
				else
					jit = rand_between(-(span / 2), span / 2);
				send_offset(base + jit, $urandom_range(0, 99) < 4);
			end
			if (i == items / 2 && $urandom_range(0, 1) == 1)
				wait_idle();
		end
	endtask

	initial begin
		logic [THR_W-1:0]  thr;
		logic [MINC_W-1:0] minc;
		int                r;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.audio_stamp = '0;
		sample.video_stamp = '0;
		sample.ctx_flush = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: extreme stamps, outlier clear, context clear
		send_sample(STAMP_MAX, '0, 1'b0);
		send_sample(STAMP_MAX - 1, '0, 1'b0);
		send_sample(STAMP_MAX - 3, '0, 1'b0);
		send_sample(STAMP_MAX, 63'd1, 1'b0);
		send_sample('0, STAMP_MAX, 1'b0);
		send_sample('0, STAMP_MAX - 1, 1'b0);
		send_sample(63'd1, STAMP_MAX, 1'b1);
		send_sample(63'd5, 63'd5, 1'b1);
		// exactly at the threshold stays, one past it clears
		send_sample(63'd15000005, 63'd5, 1'b0);
		send_sample(63'd22500006, 63'd5, 1'b0);
		wait_idle();

		// widest threshold, stats on every step: even-count rounding
		program_regs({THR_W{1'b1}}, '0);
		send_sample(63'd1, 63'd2, 1'b1);
		send_sample(63'd1, 63'd3, 1'b0);
		send_sample(63'd10, 63'd10, 1'b1);
		send_sample(63'd10, 63'd13, 1'b0);
		send_sample('0, STAMP_MAX, 1'b1);
		send_sample('0, STAMP_MAX - 2, 1'b0);
		send_sample(63'd7, 63'd5, 1'b1);
		send_sample(63'd8, 63'd5, 1'b0);
		wait_idle();

		// zero threshold, stats never valid
		program_regs('0, {MINC_W{1'b1}});
		send_sample(63'd100, 63'd40, 1'b1);
		send_sample(63'd200, 63'd140, 1'b0);
		send_sample(63'd201, 63'd140, 1'b0);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) begin
				thr = THR_RESET;
				minc = MINC_W'(WINDOW);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20)
					thr = '0;
				else if (r < 35)
					thr = {THR_W{1'b1}};
				else if (r < 50)
					thr = THR_W'(1000000000);
				else if (r < 75)
					thr = THR_W'($urandom_range(0, 1000));
				else
					thr = THR_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 10)
					minc = '0;
				else if (r < 20)
					minc = MINC_W'($urandom_range(10, 15));
				else
					minc = MINC_W'($urandom_range(1, WINDOW));
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			program_regs(thr, minc);
			run_phase(PHASE_ITEMS, thr);
			wait_idle();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/wmmt_pkg.sv
design/wmmt_sample_if.sv
design/wmmt_result_if.sv
design/wmmt_cfg_if.sv
design/wmmt_ctrl.sv
design/wmmt_datapath.sv
design/windowed_median_mad_tracker_core.sv
dv/wmmt_stats_checker.sv
dv/tb_top.sv
